// ===== hdl/fifo_queue_with_search_remove_unit_defines.svh =====
// Assertion macros used by the queue's top-level RTL file.
`ifndef FIFO_QUEUE_WITH_SEARCH_REMOVE_UNIT_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_REMOVE_UNIT_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define FQSR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that holds whenever its antecedent holds.
`define FQSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/fqsr_pkg.sv =====
`default_nettype none

package fqsr_pkg;

  // Queue geometry. DEPTH is a power of two so that ring addresses wrap freely.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int ID_W   = 32;
  localparam int POS_W  = 8;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_POP    = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    mode_t           mode;
    logic [ID_W-1:0] client_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]         popped_id;
    logic                    is_head;
    logic                    is_present;
    logic signed [POS_W-1:0] position;
    logic [CNT_W-1:0]        occupancy;
    status_t                 status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/fifo_queue_with_search_remove_unit.sv =====
// Channel | Direction | Handshake           | Beat
// req     | in        | req_valid/req_stall | fqsr_pkg::req_t (mode, client_id)
// rsp     | out       | rsp_valid/rsp_stall | fqsr_pkg::rsp_t (popped_id .. status)
//
// Push, refused ids and pop on an empty queue go straight to the finish state; a pop
// reads the head first. Remove and query scan the queue: one RAM read per entry,
// streamed, then the last compare and a step to close the scan.
// The single RAM read port sets the pace; no new beat is taken until the last is done.
// Reset (synchronous) empties the queue at once; RAM contents are not cleared.
// A finished result waits in the output register while the next beat is taken.
`default_nettype none

`include "fifo_queue_with_search_remove_unit_defines.svh"

module fifo_queue_with_search_remove_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire fqsr_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output fqsr_pkg::rsp_t       rsp
);

  fqsr_pkg::state_t                       state, state_next;
  logic [fqsr_pkg::ADDR_W-1:0]            hd;
  logic [fqsr_pkg::CNT_W-1:0]             cnt;
  fqsr_pkg::mode_t                        op;
  logic [fqsr_pkg::ID_W-1:0]              key;
  logic [fqsr_pkg::CNT_W-1:0]             rd_idx, chk_idx, wr_idx;
  logic                                   rvalid;
  logic                                   found;

  logic [fqsr_pkg::ID_W-1:0]              res_popped;
  logic                                   res_head, res_present;
  logic signed [fqsr_pkg::POS_W-1:0]      res_pos;
  fqsr_pkg::status_t                      res_status;

  logic                                   ram_we;
  logic [fqsr_pkg::ADDR_W-1:0]            ram_waddr, ram_raddr;
  logic [fqsr_pkg::ID_W-1:0]              ram_wdata, ram_rdata;

  logic                                   accept, issue, scan_end, rsp_free, id_zero;

  assign accept   = req_valid && !req_stall;
  assign id_zero  = (req.client_id == '0);
  assign issue    = (state == fqsr_pkg::S_SCAN) && (rd_idx != cnt);
  assign scan_end = (state == fqsr_pkg::S_SCAN) && (rd_idx == cnt) && !rvalid;
  assign rsp_free = !rsp_valid || !rsp_stall;

  // Ring buffer storage.
  fqsr_ram #(
    .WIDTH (fqsr_pkg::ID_W),
    .DEPTH (fqsr_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fqsr_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req.mode == fqsr_pkg::MODE_POP) begin
            state_next = (cnt == '0) ? fqsr_pkg::S_FIN : fqsr_pkg::S_POP;
          end else if (id_zero || req.mode == fqsr_pkg::MODE_PUSH) begin
            state_next = fqsr_pkg::S_FIN;
          end else begin
            state_next = fqsr_pkg::S_SCAN;
          end
        end
      end
      fqsr_pkg::S_POP: begin
        state_next = fqsr_pkg::S_FIN;
      end
      fqsr_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = fqsr_pkg::S_FIN;
        end
      end
      fqsr_pkg::S_FIN: begin
        if (rsp_free) begin
          state_next = fqsr_pkg::S_IDLE;
        end
      end
      default: state_next = fqsr_pkg::S_IDLE;
    endcase
  end

  // Outputs of the state machine: handshake and RAM controls.
  always_comb begin
    req_stall = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = hd;
    ram_wdata = req.client_id;
    ram_raddr = hd;
    unique case (state) inside
      fqsr_pkg::S_IDLE: begin
        req_stall = 1'b0;
        // A push goes straight into the tail slot; the head is read for a pop.
        if (req_valid && req.mode == fqsr_pkg::MODE_PUSH && !id_zero &&
            cnt != fqsr_pkg::CNT_W'(fqsr_pkg::DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = hd + cnt[fqsr_pkg::ADDR_W-1:0];
        end
      end
      fqsr_pkg::S_SCAN: begin
        ram_raddr = hd + rd_idx[fqsr_pkg::ADDR_W-1:0];
        // Compaction: survivors are written back at the write index, which
        // always trails the read index.
        if (rvalid && op == fqsr_pkg::MODE_REMOVE && ram_rdata != key) begin
          ram_we    = 1'b1;
          ram_waddr = hd + wr_idx[fqsr_pkg::ADDR_W-1:0];
          ram_wdata = ram_rdata;
        end
      end
      fqsr_pkg::S_POP,
      fqsr_pkg::S_FIN: begin
        req_stall = 1'b1;
      end
      default: req_stall = 1'b1;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fqsr_pkg::S_IDLE;
      hd        <= '0;
      cnt       <= '0;
      rvalid    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= issue;
      if (accept && req.mode == fqsr_pkg::MODE_PUSH && !id_zero &&
          cnt != fqsr_pkg::CNT_W'(fqsr_pkg::DEPTH)) begin
        cnt <= cnt + 1'b1;
      end
      if (state == fqsr_pkg::S_POP) begin
        hd  <= hd + 1'b1;
        cnt <= cnt - 1'b1;
      end
      if (scan_end && op == fqsr_pkg::MODE_REMOVE) begin
        cnt <= wr_idx;
      end
      // Output register: cleared when taken, loaded when the result is ready.
      if (state == fqsr_pkg::S_FIN && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current beat and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= req.mode;
      key         <= req.client_id;
      rd_idx      <= '0;
      chk_idx     <= '0;
      wr_idx      <= '0;
      found       <= 1'b0;
      res_popped  <= '0;
      res_head    <= 1'b0;
      res_present <= 1'b0;
      // A query of a nonzero id starts out as absent; every other beat reports position zero.
      if (req.mode == fqsr_pkg::MODE_QUERY && !id_zero) begin
        res_pos <= '1;
      end else begin
        res_pos <= '0;
      end
      if (req.mode == fqsr_pkg::MODE_POP) begin
        if (cnt == '0) begin
          res_status <= fqsr_pkg::ST_EMPTY;
        end else begin
          res_status <= fqsr_pkg::ST_OK;
        end
      end else if (id_zero) begin
        res_status <= fqsr_pkg::ST_ZERO;
      end else if (req.mode == fqsr_pkg::MODE_PUSH &&
                   cnt == fqsr_pkg::CNT_W'(fqsr_pkg::DEPTH)) begin
        res_status <= fqsr_pkg::ST_FULL;
      end else begin
        res_status <= fqsr_pkg::ST_OK;
      end
    end
    if (state == fqsr_pkg::S_POP) begin
      res_popped <= ram_rdata;
    end
    if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
    // Compare each entry as its read data returns.
    if (rvalid) begin
      chk_idx <= chk_idx + 1'b1;
      if (op == fqsr_pkg::MODE_REMOVE) begin
        if (ram_rdata != key) begin
          wr_idx <= wr_idx + 1'b1;
        end
      end else if (ram_rdata == key && !found) begin
        found       <= 1'b1;
        res_present <= 1'b1;
        res_pos     <= fqsr_pkg::POS_W'(chk_idx) + fqsr_pkg::POS_W'(1);
        res_head    <= (chk_idx == '0);
      end
    end
    if (state == fqsr_pkg::S_FIN && rsp_free) begin
      rsp.popped_id  <= res_popped;
      rsp.is_head    <= res_head;
      rsp.is_present <= res_present;
      rsp.position   <= res_pos;
      rsp.occupancy  <= cnt;
      rsp.status     <= res_status;
    end
  end

  // Checks on the queue's own bookkeeping.
  `FQSR_ASSERT_ALWAYS(a_cnt_range, cnt <= fqsr_pkg::CNT_W'(fqsr_pkg::DEPTH),
                      "count beyond depth")
  `FQSR_ASSERT_IMPL(a_wr_trails, state == fqsr_pkg::S_SCAN,
                    wr_idx <= chk_idx && chk_idx <= rd_idx, "compaction index ahead of scan")
  `FQSR_ASSERT_IMPL(a_rvalid_scan, rvalid,
                    $past(state) == fqsr_pkg::S_SCAN && state == fqsr_pkg::S_SCAN,
                    "read data outside a scan")
  `FQSR_ASSERT_IMPL(a_full_occ, rsp_valid && rsp.status == fqsr_pkg::ST_FULL,
                    rsp.occupancy == fqsr_pkg::CNT_W'(fqsr_pkg::DEPTH),
                    "full drop with room left")
  `FQSR_ASSERT_IMPL(a_empty_pop, rsp_valid && rsp.status == fqsr_pkg::ST_EMPTY,
                    rsp.occupancy == '0 && rsp.popped_id == '0, "empty pop with data")

endmodule

`default_nettype wire

// ===== hdl/fqsr_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module fqsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== dv/fifo_queue_with_search_remove_unit_test.sv =====
`timescale 1ns / 1ps

module fifo_queue_with_search_remove_unit_test;

  // Cycles with no beat on either side before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Cycles left after the last response for any stray beat to show up.
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_BEATS = 1050;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_t;

  typedef struct {
    fqsr_pkg::req_t beat;
    bit             settle;
  } pending_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  fqsr_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  fqsr_pkg::rsp_t rsp;

  // Requests still to be sent, and responses still owed by the queue.
  pending_t req_backlog[$];
  fqsr_pkg::rsp_t due_results[$];

  // Shadow copy of the stored ids; index 0 is the head.
  logic [fqsr_pkg::ID_W-1:0] stored_ids[$];
  // Ids recently pushed, so that removes and queries hit deep entries.
  logic [fqsr_pkg::ID_W-1:0] pushed_log[$];

  bit req_fire = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int tx_hold = 0;
  int rx_hold = 0;
  int idle_cycles = 0;
  int mismatches = 0;

  fifo_queue_with_search_remove_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow queue and return the response it owes.
  function automatic fqsr_pkg::rsp_t apply_queue_op(fqsr_pkg::req_t r);
    fqsr_pkg::rsp_t res;
    res = '0;
    res.status = fqsr_pkg::ST_OK;
    if (r.mode == fqsr_pkg::MODE_POP) begin
      if (stored_ids.size() == 0) begin
        res.status = fqsr_pkg::ST_EMPTY;
      end else begin
        res.popped_id = stored_ids[0];
        stored_ids.delete(0);
      end
    end else if (r.client_id == '0) begin
      res.status = fqsr_pkg::ST_ZERO;
    end else begin
      case (r.mode)
        fqsr_pkg::MODE_PUSH: begin
          if (stored_ids.size() >= fqsr_pkg::DEPTH) begin
            res.status = fqsr_pkg::ST_FULL;
          end else begin
            stored_ids.insert(stored_ids.size(), r.client_id);
          end
        end
        fqsr_pkg::MODE_REMOVE: begin
          for (int i = stored_ids.size() - 1; i >= 0; i--) begin
            if (stored_ids[i] == r.client_id) stored_ids.delete(i);
          end
        end
        default: begin
          res.position = '1;
          if (stored_ids.size() != 0 && stored_ids[0] == r.client_id) res.is_head = 1'b1;
          for (int i = 0; i < stored_ids.size(); i++) begin
            if (stored_ids[i] == r.client_id) begin
              res.is_present = 1'b1;
              res.position = fqsr_pkg::POS_W'(i + 1);
              break;
            end
          end
        end
      endcase
    end
    res.occupancy = fqsr_pkg::CNT_W'(stored_ids.size());
    return res;
  endfunction

  // Mostly back-to-back, now and then a short pause, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [fqsr_pkg::ID_W-1:0] pick_id();
    logic [fqsr_pkg::ID_W-1:0] pool[6];
    int roll;
    pool = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h5A5A_A5A5, 32'h0000_00FF};
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 40) return pool[$urandom_range(0, 5)];
    if (roll < 70 && pushed_log.size() != 0) begin
      return pushed_log[$urandom_range(0, pushed_log.size() - 1)];
    end
    return $urandom();
  endfunction

  function automatic fqsr_pkg::mode_t pick_mode(phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (roll < 70) return fqsr_pkg::MODE_PUSH;
        if (roll < 75) return fqsr_pkg::MODE_REMOVE;
        if (roll < 80) return fqsr_pkg::MODE_POP;
        return fqsr_pkg::MODE_QUERY;
      end
      PH_DRAIN: begin
        if (roll < 10) return fqsr_pkg::MODE_PUSH;
        if (roll < 20) return fqsr_pkg::MODE_REMOVE;
        if (roll < 80) return fqsr_pkg::MODE_POP;
        return fqsr_pkg::MODE_QUERY;
      end
      default: begin
        if (roll < 35) return fqsr_pkg::MODE_PUSH;
        if (roll < 50) return fqsr_pkg::MODE_REMOVE;
        if (roll < 75) return fqsr_pkg::MODE_POP;
        return fqsr_pkg::MODE_QUERY;
      end
    endcase
  endfunction

  task automatic queue_beat(fqsr_pkg::mode_t m, logic [fqsr_pkg::ID_W-1:0] id,
                            bit settle = 1'b0);
    pending_t p;
    p.beat.mode = m;
    p.beat.client_id = id;
    p.settle = settle;
    req_backlog.insert(req_backlog.size(), p);
    if (m == fqsr_pkg::MODE_PUSH && id != '0) begin
      pushed_log.insert(pushed_log.size(), id);
      if (pushed_log.size() > fqsr_pkg::DEPTH) pushed_log.delete(0);
    end
  endtask

  task automatic check_result(fqsr_pkg::rsp_t got);
    fqsr_pkg::rsp_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Unexpected response: popped %h head %b present %b pos %0d occ %0d status %0d",
                 got.popped_id, got.is_head, got.is_present, got.position, got.occupancy,
                 got.status);
      end
    end else begin
      want = due_results[0];
      due_results.delete(0);
      if (got.popped_id !== want.popped_id || got.is_head !== want.is_head ||
          got.is_present !== want.is_present || got.position !== want.position ||
          got.occupancy !== want.occupancy || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Mismatch: expected popped %h head %b present %b pos %0d occ %0d st %0d",
                   want.popped_id, want.is_head, want.is_present, want.position,
                   want.occupancy, want.status);
          $display("          actual   popped %h head %b present %b pos %0d occ %0d st %0d",
                   got.popped_id, got.is_head, got.is_present, got.position, got.occupancy,
                   got.status);
        end
      end
    end
  endtask

  // Request driver: a presented beat is held until taken, then a fresh gap is drawn.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        tx_hold = tx_burst ? 0 : pick_gap();
        if ($urandom_range(0, 149) == 0) tx_burst = ~tx_burst;
      end
      if (req_valid && !req_fire) begin
        // The current beat has not been taken yet; leave it alone.
      end else if (tx_hold > 0) begin
        req_valid <= 1'b0;
        tx_hold--;
      end else if (req_backlog.size() != 0 &&
                   !(req_backlog[0].settle && due_results.size() != 0)) begin
        req_valid <= 1'b1;
        req <= req_backlog[0].beat;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response back-pressure, with occasional stretches of none at all.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rsp_stall <= 1'b1;
      rx_hold--;
    end else begin
      rsp_stall <= 1'b0;
      if ($urandom_range(0, 199) == 0) rx_burst = ~rx_burst;
      if (!rx_burst && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
    end
  end

  // Monitor: predict on every request beat, check every response beat, watch for hangs.
  always @(posedge clk) begin
    if (rst) begin
      req_fire = 1'b0;
      idle_cycles = 0;
    end else begin
      req_fire = req_valid && !req_stall;
      if (req_fire) begin
        due_results.insert(due_results.size(), apply_queue_op(req));
        req_backlog.delete(0);
      end
      if (rsp_valid && !rsp_stall) check_result(rsp);
      if (req_fire || (rsp_valid && !rsp_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    phase_t ph;
    int phase_left;
    fqsr_pkg::mode_t m;

    // Directed: empty-queue cases, refused zero ids, duplicates and extreme ids.
    queue_beat(fqsr_pkg::MODE_POP, 32'h0000_0000);
    queue_beat(fqsr_pkg::MODE_QUERY, 32'h0000_0001);
    queue_beat(fqsr_pkg::MODE_PUSH, 32'h0000_0000);
    queue_beat(fqsr_pkg::MODE_REMOVE, 32'h0000_0000);
    queue_beat(fqsr_pkg::MODE_QUERY, 32'h0000_0000);
    queue_beat(fqsr_pkg::MODE_POP, 32'hFFFF_FFFF);
    queue_beat(fqsr_pkg::MODE_PUSH, 32'hFFFF_FFFF);
    queue_beat(fqsr_pkg::MODE_PUSH, 32'h0000_0001);
    queue_beat(fqsr_pkg::MODE_PUSH, 32'h8000_0000);
    queue_beat(fqsr_pkg::MODE_PUSH, 32'hFFFF_FFFF);
    queue_beat(fqsr_pkg::MODE_QUERY, 32'hFFFF_FFFF);
    queue_beat(fqsr_pkg::MODE_QUERY, 32'h0000_0001);
    queue_beat(fqsr_pkg::MODE_QUERY, 32'h0000_0005);
    queue_beat(fqsr_pkg::MODE_PUSH, 32'h0000_0000);
    queue_beat(fqsr_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
    queue_beat(fqsr_pkg::MODE_REMOVE, 32'h0000_0007);
    queue_beat(fqsr_pkg::MODE_QUERY, 32'h8000_0000);
    queue_beat(fqsr_pkg::MODE_QUERY, 32'hFFFF_FFFF);
    queue_beat(fqsr_pkg::MODE_POP, 32'h0000_0000);
    queue_beat(fqsr_pkg::MODE_POP, 32'h1234_5678);
    queue_beat(fqsr_pkg::MODE_POP, 32'h0000_0000);
    queue_beat(fqsr_pkg::MODE_QUERY, 32'h0000_0001);

    // Random: filling, draining and mixed phases in random order; the first is a filling one.
    ph = PH_FILL;
    phase_left = 180;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (phase_left == 0) begin
        ph = phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(60, 180);
      end
      phase_left--;
      m = pick_mode(ph);
      queue_beat(m, pick_id(), n == 0 || $urandom_range(0, 199) == 0);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== fifo_queue_with_search_remove_unit.f =====
+incdir+hdl
hdl/fqsr_pkg.sv
hdl/fqsr_ram.sv
hdl/fifo_queue_with_search_remove_unit.sv
dv/fifo_queue_with_search_remove_unit_test.sv
